/* hw/rtl/hrlp_pkg.sv */
package hrlp_pkg;

    localparam int METHOD_MAX_LEN  = 15;
    localparam int PATH_MAX_LEN    = 255;
    localparam int VERSION_MAX_LEN = 15;
    localparam int QUERY_BYTES     = 256;

    localparam int MAX_TOK_LEN =
        (METHOD_MAX_LEN > PATH_MAX_LEN) ?
            ((METHOD_MAX_LEN > VERSION_MAX_LEN) ? METHOD_MAX_LEN : VERSION_MAX_LEN) :
            ((PATH_MAX_LEN > VERSION_MAX_LEN) ? PATH_MAX_LEN : VERSION_MAX_LEN);
    localparam int TOK_W = $clog2(MAX_TOK_LEN + 1);
    localparam int QL_W  = $clog2(QUERY_BYTES);

    localparam logic [QL_W-1:0] QUERY_KEEP_MAX = QL_W'(QUERY_BYTES - 1);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [2:0][7:0] GET_WORD = {8'h54, 8'h45, 8'h47};
    localparam logic [7:0][7:0] VER_WORD = "1.1/PTTH";
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [2:0] MM_LEN = 3'd3;
    localparam logic [2:0] MM_BAD = 3'd7;
    localparam logic [3:0] VM_LEN = 4'd8;
    localparam logic [3:0] VM_BAD = 4'd15;

    localparam logic [1:0] FI_METHOD  = 2'd0;
    localparam logic [1:0] FI_PATH    = 2'd1;
    localparam logic [1:0] FI_VERSION = 2'd2;
    localparam logic [1:0] FI_DONE    = 2'd3;

    localparam logic [2:0] TAG_SEP     = 3'd0;
    localparam logic [2:0] TAG_METHOD  = 3'd1;
    localparam logic [2:0] TAG_PATH    = 3'd2;
    localparam logic [2:0] TAG_QUERY   = 3'd3;
    localparam logic [2:0] TAG_VERSION = 3'd4;
    localparam logic [2:0] TAG_TRAIL   = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_GET   = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;
    localparam logic [1:0] ST_TOO_FEW   = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] byte_tag;
        logic       is_last;
        logic [1:0] head_status;
    } t_out_item;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       is_zero;
        logic       is_blank;
        logic       is_qmark;
        logic       is_slash;
        logic [2:0] get_hit;
        logic [7:0] ver_hit;
    } t_cls;

    function automatic logic [TOK_W-1:0] field_limit(input logic [1:0] fi);
        logic [TOK_W-1:0] lim;
        if (fi == FI_METHOD) begin
            lim = TOK_W'(METHOD_MAX_LEN);
        end else if (fi == FI_PATH) begin
            lim = TOK_W'(PATH_MAX_LEN);
        end else begin
            lim = TOK_W'(VERSION_MAX_LEN);
        end
        return lim;
    endfunction

endpackage

/* hw/rtl/hrlp_front.sv */
module hrlp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  hrlp_pkg::t_in_item i_in_item,
    output logic               o_full,
    output logic               o_cls_valid,
    output hrlp_pkg::t_cls     o_cls,
    input  logic               i_cls_take
);

    hrlp_pkg::t_cls r_mem [hrlp_pkg::QDEPTH];
    logic [hrlp_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [hrlp_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [hrlp_pkg::QCNT_W-1:0] r_cnt;
    hrlp_pkg::t_cls cls;
    logic wr_en;
    logic rd_en;

    always_comb begin
        cls.data     = i_in_item.in_byte;
        cls.last     = i_in_item.last_byte;
        cls.is_zero  = (i_in_item.in_byte == 8'h00);
        cls.is_blank = (i_in_item.in_byte == hrlp_pkg::CH_SPACE) ||
                       ((i_in_item.in_byte >= hrlp_pkg::CH_TAB) &&
                        (i_in_item.in_byte <= hrlp_pkg::CH_CR));
        cls.is_qmark = (i_in_item.in_byte == hrlp_pkg::CH_QMARK);
        cls.is_slash = (i_in_item.in_byte == hrlp_pkg::CH_SLASH);
        for (int i = 0; i < 3; i++) begin
            cls.get_hit[i] = (i_in_item.in_byte == hrlp_pkg::GET_WORD[i]);
        end
        for (int i = 0; i < 8; i++) begin
            cls.ver_hit[i] = (i_in_item.in_byte == hrlp_pkg::VER_WORD[i]);
        end
    end

    assign o_full      = (r_cnt == hrlp_pkg::QCNT_W'(hrlp_pkg::QDEPTH));
    assign o_cls_valid = (r_cnt != '0);
    assign o_cls       = r_mem[r_rd_ptr];
    assign wr_en       = i_push && !o_full;
    assign rd_en       = i_cls_take && o_cls_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/hrlp_back.sv */
module hrlp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cls_valid,
    input  hrlp_pkg::t_cls      i_cls,
    output logic                o_cls_take,
    output logic                o_empty,
    output hrlp_pkg::t_out_item o_out_item,
    input  logic                i_pop
);

    logic [1:0]                r_fi;
    logic                      r_in_tok;
    logic [hrlp_pkg::TOK_W-1:0] r_tl;
    logic                      r_iq;
    logic [hrlp_pkg::QL_W-1:0]  r_ql;
    logic [2:0]                r_mm;
    logic [3:0]                r_vm;
    logic                      r_pss;
    logic                      r_ended;

    logic [1:0]                n_fi;
    logic                      n_in_tok;
    logic [hrlp_pkg::TOK_W-1:0] n_tl;
    logic                      n_iq;
    logic [hrlp_pkg::QL_W-1:0]  n_ql;
    logic [2:0]                n_mm;
    logic [3:0]                n_vm;
    logic                      n_pss;
    logic                      n_ended;

    hrlp_pkg::t_out_item r_mem [hrlp_pkg::QDEPTH];
    logic [hrlp_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [hrlp_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [hrlp_pkg::QCNT_W-1:0] r_cnt;

    hrlp_pkg::t_out_item res;
    logic [hrlp_pkg::TOK_W:0] tl_inc;
    logic [2:0] tokens;
    logic take;
    logic rd_en;

    assign take       = i_cls_valid && (r_cnt != hrlp_pkg::QCNT_W'(hrlp_pkg::QDEPTH));
    assign o_cls_take = take;
    assign o_empty    = (r_cnt == '0);
    assign o_out_item = r_mem[r_rd_ptr];
    assign rd_en      = i_pop && !o_empty;

    always_comb begin
        n_fi     = r_fi;
        n_in_tok = r_in_tok;
        n_tl     = r_tl;
        n_iq     = r_iq;
        n_ql     = r_ql;
        n_mm     = r_mm;
        n_vm     = r_vm;
        n_pss    = r_pss;
        n_ended  = r_ended;
        tl_inc   = '0;
        tokens   = '0;
        res.out_byte    = i_cls.data;
        res.byte_tag    = hrlp_pkg::TAG_SEP;
        res.is_last     = i_cls.last;
        res.head_status = hrlp_pkg::ST_OK;

        if (r_ended || (r_fi == hrlp_pkg::FI_DONE)) begin
            res.byte_tag = hrlp_pkg::TAG_TRAIL;
        end else if (i_cls.is_zero) begin
            n_ended      = 1'b1;
            res.byte_tag = hrlp_pkg::TAG_TRAIL;
        end else if (i_cls.is_blank) begin
            if (r_in_tok) begin
                n_fi     = r_fi + 2'd1;
                n_in_tok = 1'b0;
                n_tl     = '0;
            end
        end else begin
            if (!r_in_tok) begin
                n_in_tok = 1'b1;
                n_tl     = '0;
                if (r_fi == hrlp_pkg::FI_PATH) begin
                    n_pss = i_cls.is_slash;
                    n_iq  = 1'b0;
                    n_ql  = '0;
                end
            end
            unique case (r_fi)
                hrlp_pkg::FI_METHOD: begin
                    res.byte_tag = hrlp_pkg::TAG_METHOD;
                    if ((r_mm < hrlp_pkg::MM_LEN) && i_cls.get_hit[r_mm[1:0]]) begin
                        n_mm = r_mm + 3'd1;
                    end else begin
                        n_mm = hrlp_pkg::MM_BAD;
                    end
                end
                hrlp_pkg::FI_PATH: begin
                    if (n_iq) begin
                        if (n_ql < hrlp_pkg::QUERY_KEEP_MAX) begin
                            n_ql         = n_ql + 1'b1;
                            res.byte_tag = hrlp_pkg::TAG_QUERY;
                        end else begin
                            res.byte_tag = hrlp_pkg::TAG_SEP;
                        end
                    end else if (i_cls.is_qmark) begin
                        n_iq         = 1'b1;
                        res.byte_tag = hrlp_pkg::TAG_SEP;
                    end else begin
                        res.byte_tag = hrlp_pkg::TAG_PATH;
                    end
                end
                default: begin
                    res.byte_tag = hrlp_pkg::TAG_VERSION;
                    if ((r_vm < hrlp_pkg::VM_LEN) && i_cls.ver_hit[r_vm[2:0]]) begin
                        n_vm = r_vm + 4'd1;
                    end else begin
                        n_vm = hrlp_pkg::VM_BAD;
                    end
                end
            endcase
            tl_inc = {1'b0, n_tl} + 1'b1;
            if (tl_inc >= {1'b0, hrlp_pkg::field_limit(r_fi)}) begin
                n_fi     = r_fi + 2'd1;
                n_in_tok = 1'b0;
                n_tl     = '0;
            end else begin
                n_tl = tl_inc[hrlp_pkg::TOK_W-1:0];
            end
        end

        if (i_cls.last) begin
            tokens = {1'b0, n_fi} + {2'b00, n_in_tok};
            if (tokens < 3'd3) begin
                res.head_status = hrlp_pkg::ST_TOO_FEW;
            end else if (n_mm != hrlp_pkg::MM_LEN) begin
                res.head_status = hrlp_pkg::ST_NOT_GET;
            end else if ((n_vm != hrlp_pkg::VM_LEN) || !n_pss) begin
                res.head_status = hrlp_pkg::ST_MALFORMED;
            end
            n_fi     = hrlp_pkg::FI_METHOD;
            n_in_tok = 1'b0;
            n_tl     = '0;
            n_iq     = 1'b0;
            n_ql     = '0;
            n_mm     = '0;
            n_vm     = '0;
            n_pss    = 1'b0;
            n_ended  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_mem[r_wr_ptr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fi     <= hrlp_pkg::FI_METHOD;
            r_in_tok <= 1'b0;
            r_tl     <= '0;
            r_iq     <= 1'b0;
            r_ql     <= '0;
            r_mm     <= '0;
            r_vm     <= '0;
            r_pss    <= 1'b0;
            r_ended  <= 1'b0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (take) begin
                r_fi     <= n_fi;
                r_in_tok <= n_in_tok;
                r_tl     <= n_tl;
                r_iq     <= n_iq;
                r_ql     <= n_ql;
                r_mm     <= n_mm;
                r_vm     <= n_vm;
                r_pss    <= n_pss;
                r_ended  <= n_ended;
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (take && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !take) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/http_request_line_parser_top.sv */
// HTTP request line parser. Bytes of a request head enter through a queue-like
// input (push, full) and leave through a queue-like output (empty, pop), one
// result transaction for each input transaction, in order.
// Each result carries the byte, its tag (separator, method, path, query,
// version or trailing), a last flag, and on the last byte the line status.
// An accepted byte is classified and stored in the classification queue; the
// back end then takes it into the result queue once that queue has room, and
// from there it can be popped. Throughput is one byte per cycle while the
// receiver keeps popping, set by the back end state update; a two-entry
// classification queue and a two-entry result queue sit between the stages.
// A synchronous active-low reset empties both queues and returns the parser to
// the start of a request line. The byte marked last also returns it there.
// When the receiver stops popping, the result queue fills, the back end stops
// taking classified bytes, and full rises after the front queue fills too; no
// transaction is lost or repeated.
module http_request_line_parser_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  hrlp_pkg::t_in_item  i_in_item,
    output logic                empty,
    input  logic                pop,
    output hrlp_pkg::t_out_item o_out_item
);

    hrlp_pkg::t_cls cls;
    logic           cls_valid;
    logic           cls_take;

    hrlp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_in_item   (i_in_item),
        .o_full      (full),
        .o_cls_valid (cls_valid),
        .o_cls       (cls),
        .i_cls_take  (cls_take)
    );

    hrlp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls_valid (cls_valid),
        .i_cls       (cls),
        .o_cls_take  (cls_take),
        .o_empty     (empty),
        .o_out_item  (o_out_item),
        .i_pop       (pop)
    );

endmodule

/* hw/rtl/hrlp_checker.sv */
module hrlp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                push,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input hrlp_pkg::t_out_item o_out_item
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("Queues are not empty after reset.");

    a_status_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_out_item.is_last |-> o_out_item.head_status == hrlp_pkg::ST_OK)
        else $error("Status reported on a byte that is not last.");

    a_tag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_out_item.byte_tag <= hrlp_pkg::TAG_TRAIL)
        else $error("Byte tag out of range.");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_item))
        else $error("Waiting result transaction changed or vanished.");

    a_push_reaches_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !full |-> ##2 !empty)
        else $error("Result queue is empty two cycles after an accepted transaction.");

endmodule

bind http_request_line_parser_top hrlp_checker u_hrlp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .push       (push),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .o_out_item (o_out_item)
);
